@@ design/rhb_pkg.sv @@
// ----------------------------------------------------------------------------
// rhb_pkg
// Shared widths, codes and the sideband word carried down the brush pipeline.
// ----------------------------------------------------------------------------
package rhb_pkg;

  localparam int GRID_SIZE = 1024;

  localparam int CRD_W  = 11;
  localparam int FRAC_W = 8;
  localparam int FIX_W  = CRD_W + FRAC_W;
  localparam int HGT_W  = 32;
  localparam int BW_W   = 31;
  localparam int OP_W   = 3;
  localparam int SQ_W   = 2 * FIX_W;
  localparam int QW     = 16;
  localparam int W_W    = QW + 1;
  localparam int PROD_W = W_W + BW_W;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [OP_W-1:0] OP_RAISE   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOWER   = 3'd1;
  localparam logic [OP_W-1:0] OP_FLATTEN = 3'd2;
  localparam logic [OP_W-1:0] OP_SMOOTH  = 3'd3;
  localparam logic [OP_W-1:0] OP_NONE    = 3'd4;

  localparam logic [W_W-1:0] W_ONE = W_W'(1) << QW;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPERATION      = 3'd0,
    REG_CENTER_X       = 3'd1,
    REG_CENTER_Y       = 3'd2,
    REG_OUTER_RADIUS   = 3'd3,
    REG_INNER_RADIUS   = 3'd4,
    REG_BRUSH_WEIGHT   = 3'd5,
    REG_AVERAGE_HEIGHT = 3'd6
  } rhb_reg_t;

  typedef enum logic [1:0] {
    WSEL_DIV,
    WSEL_FULL,
    WSEL_ZERO
  } rhb_wsel_t;

  typedef struct packed {
    logic [CRD_W-1:0]        x;
    logic [CRD_W-1:0]        y;
    logic signed [HGT_W-1:0] h;
    logic                    act;
    logic                    up;
    rhb_wsel_t               wsel;
  } rhb_side_t;

endpackage

@@ design/rhb_div.sv @@
// ----------------------------------------------------------------------------
// rhb_div
// Pipelined restoring divider: one quotient bit per stage, numerator below
// the divisor, quotient = floor(rem * 2^QW / den). Sideband rides along.
// ----------------------------------------------------------------------------
module rhb_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  output logic                   in_rdy,
  input  logic [rhb_pkg::SQ_W-1:0] in_rem,
  input  logic [rhb_pkg::SQ_W-1:0] in_den,
  input  rhb_pkg::rhb_side_t     in_side,
  output logic                   out_vld,
  input  logic                   out_rdy,
  output logic [rhb_pkg::QW-1:0] out_q,
  output rhb_pkg::rhb_side_t     out_side
);
  import rhb_pkg::*;

  logic            vld_r  [QW];
  logic [SQ_W-1:0] rem_r  [QW];
  logic [SQ_W-1:0] den_r  [QW];
  logic [QW-1:0]   q_r    [QW];
  rhb_side_t       side_r [QW];

  logic            rdy      [QW+1];
  logic            src_vld  [QW];
  logic [SQ_W-1:0] src_rem  [QW];
  logic [SQ_W-1:0] src_den  [QW];
  logic [QW-1:0]   src_q    [QW];
  rhb_side_t       src_side [QW];
  logic [SQ_W-1:0] rem_nxt  [QW];
  logic [QW-1:0]   q_nxt    [QW];

  assign rdy[QW] = out_rdy;

  for (genvar k = 0; k < QW; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        src_vld[k]  = in_vld;
        src_rem[k]  = in_rem;
        src_den[k]  = in_den;
        src_q[k]    = '0;
        src_side[k] = in_side;
      end else begin
        src_vld[k]  = vld_r[k-1];
        src_rem[k]  = rem_r[k-1];
        src_den[k]  = den_r[k-1];
        src_q[k]    = q_r[k-1];
        src_side[k] = side_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic [SQ_W:0] shf;
    logic [SQ_W:0] dif;
    logic          ge;
    assign shf = {src_rem[k], 1'b0};
    assign dif = shf - {1'b0, src_den[k]};
    assign ge  = shf >= {1'b0, src_den[k]};
    assign rem_nxt[k] = ge ? dif[SQ_W-1:0] : shf[SQ_W-1:0];
    assign q_nxt[k]   = {src_q[k][QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rdy[k]) begin
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= src_den[k];
        q_r[k]    <= q_nxt[k];
        side_r[k] <= src_side[k];
      end
    end
  end

  assign in_rdy   = rdy[0];
  assign out_vld  = vld_r[QW-1];
  assign out_q    = q_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

@@ design/radial_heightmap_brush_core.sv @@
// ----------------------------------------------------------------------------
// radial_heightmap_brush_core
// Edits one heightmap cell per word: radial weight from squared distance,
// falloff by pipelined division, raise / lower / flatten / smooth, saturated result.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | cell_x, cell_y, cell_height
//   out_    | output    | out_valid / out_stall | out_x, out_y, out_height
//   cfg_    | input     | cfg_we                | cfg_idx, cfg_wdata
//
// One word per cycle sustained while out_stall is low; 3 front stages, 16
// divider stages, then weight multiply, saturate and output register.
// The one-bit-per-stage divider sets the depth.
// Synchronous active-low reset clears all valid bits and loads register
// reset values; no clearing pass. A stage holds only when the stage after
// it is full and held, so bubbles close up under out_stall.
// ----------------------------------------------------------------------------
module radial_heightmap_brush_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rhb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rhb_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rhb_pkg::CRD_W-1:0]       in_cell_x,
  input  logic [rhb_pkg::CRD_W-1:0]       in_cell_y,
  input  logic signed [rhb_pkg::HGT_W-1:0] in_cell_height,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rhb_pkg::CRD_W-1:0]       out_x,
  output logic [rhb_pkg::CRD_W-1:0]       out_y,
  output logic signed [rhb_pkg::HGT_W-1:0] out_height
);
  import rhb_pkg::*;

  logic [OP_W-1:0]         op_r;
  logic [FIX_W-1:0]        cen_x_r;
  logic [FIX_W-1:0]        cen_y_r;
  logic [FIX_W-1:0]        outer_r;
  logic [FIX_W-1:0]        inner_r;
  logic [BW_W-1:0]         bweight_r;
  logic signed [HGT_W-1:0] avg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r      <= OP_NONE;
      cen_x_r   <= '0;
      cen_y_r   <= '0;
      outer_r   <= FIX_W'(256);
      inner_r   <= '0;
      bweight_r <= BW_W'(65536);
      avg_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OPERATION:      op_r      <= cfg_wdata[OP_W-1:0];
        REG_CENTER_X:       cen_x_r   <= cfg_wdata[FIX_W-1:0];
        REG_CENTER_Y:       cen_y_r   <= cfg_wdata[FIX_W-1:0];
        REG_OUTER_RADIUS:   outer_r   <= cfg_wdata[FIX_W-1:0];
        REG_INNER_RADIUS:   inner_r   <= cfg_wdata[FIX_W-1:0];
        REG_BRUSH_WEIGHT:   bweight_r <= cfg_wdata[BW_W-1:0];
        REG_AVERAGE_HEIGHT: avg_r     <= cfg_wdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic div_in_rdy;
  logic div_out_vld;
  logic [QW-1:0] div_q;
  rhb_side_t div_side;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  assign rdy5 = !out_valid_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || div_in_rdy;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // stage 1: distances, operation decode
  logic [FIX_W-1:0] cx_fix, cy_fix;
  logic [FIX_W-1:0] dx_nxt, dy_nxt;
  logic             in_grid;
  rhb_side_t        side1_nxt;
  logic [FIX_W-1:0] dx1_r, dy1_r;
  rhb_side_t        side1_r;

  assign cx_fix  = {in_cell_x, {FRAC_W{1'b0}}};
  assign cy_fix  = {in_cell_y, {FRAC_W{1'b0}}};
  assign dx_nxt  = (cx_fix >= cen_x_r) ? cx_fix - cen_x_r : cen_x_r - cx_fix;
  assign dy_nxt  = (cy_fix >= cen_y_r) ? cy_fix - cen_y_r : cen_y_r - cy_fix;
  assign in_grid = (32'(in_cell_x) <= GRID_SIZE) && (32'(in_cell_y) <= GRID_SIZE);

  always_comb begin
    side1_nxt      = '0;
    side1_nxt.x    = in_cell_x;
    side1_nxt.y    = in_cell_y;
    side1_nxt.h    = in_cell_height;
    side1_nxt.act  = in_grid && (op_r <= OP_SMOOTH);
    side1_nxt.wsel = WSEL_DIV;
    case (op_r)
      OP_RAISE: side1_nxt.up = 1'b1;
      OP_LOWER: side1_nxt.up = 1'b0;
      default:  side1_nxt.up = in_cell_height < avg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx1_r   <= dx_nxt;
      dy1_r   <= dy_nxt;
      side1_r <= side1_nxt;
    end
  end

  // stage 2: squares
  logic [SQ_W-1:0] dxsq_nxt, dysq_nxt, isq_nxt, osq_nxt;
  logic [SQ_W-1:0] dxsq2_r, dysq2_r, isq2_r, osq2_r;
  rhb_side_t       side2_r;

  assign dxsq_nxt = dx1_r * dx1_r;
  assign dysq_nxt = dy1_r * dy1_r;
  assign isq_nxt  = inner_r * inner_r;
  assign osq_nxt  = outer_r * outer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      dxsq2_r <= dxsq_nxt;
      dysq2_r <= dysq_nxt;
      isq2_r  <= isq_nxt;
      osq2_r  <= osq_nxt;
      side2_r <= side1_r;
    end
  end

  // stage 3: classify against the radii, form the falloff numerator
  logic [SQ_W:0]   d2;
  logic [SQ_W-1:0] rem_nxt;
  rhb_side_t       side3_nxt;
  logic [SQ_W-1:0] rem3_r, den3_r;
  rhb_side_t       side3_r;

  assign d2      = {1'b0, dxsq2_r} + {1'b0, dysq2_r};
  assign rem_nxt = osq2_r - d2[SQ_W-1:0];

  always_comb begin
    side3_nxt = side2_r;
    if (d2 <= {1'b0, isq2_r}) begin
      side3_nxt.wsel = WSEL_FULL;
    end else if (d2 >= {1'b0, osq2_r}) begin
      side3_nxt.wsel = WSEL_ZERO;
    end else begin
      side3_nxt.wsel = WSEL_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      rem3_r  <= rem_nxt;
      den3_r  <= osq2_r;
      side3_r <= side3_nxt;
    end
  end

  rhb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v3_r),
    .in_rdy   (div_in_rdy),
    .in_rem   (rem3_r),
    .in_den   (den3_r),
    .in_side  (side3_r),
    .out_vld  (div_out_vld),
    .out_rdy  (rdy4),
    .out_q    (div_q),
    .out_side (div_side)
  );

  // stage 4: weight times brush weight
  logic [W_W-1:0]    w_sel;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod4_r;
  rhb_side_t         side4_r;

  always_comb begin
    case (div_side.wsel)
      WSEL_FULL: w_sel = W_ONE;
      WSEL_ZERO: w_sel = '0;
      default:   w_sel = {1'b0, div_q};
    endcase
  end

  assign prod_nxt = w_sel * bweight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= div_out_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      prod4_r <= prod_nxt;
      side4_r <= div_side;
    end
  end

  // stage 5: apply and saturate
  logic [BW_W-1:0]         add_amt;
  logic signed [HGT_W+1:0] h_ext, add_ext, sum;
  logic signed [HGT_W-1:0] hgt_nxt;
  logic [CRD_W-1:0]        out_x_r, out_y_r;
  logic signed [HGT_W-1:0] out_hgt_r;

  assign add_amt = prod4_r[QW+BW_W-1:QW];
  assign h_ext   = {{2{side4_r.h[HGT_W-1]}}, side4_r.h};
  assign add_ext = {3'b000, add_amt};
  assign sum     = side4_r.up ? h_ext + add_ext : h_ext - add_ext;

  always_comb begin
    if (!side4_r.act) begin
      hgt_nxt = side4_r.h;
    end else if (sum[HGT_W+1:HGT_W-1] == 3'b000 || sum[HGT_W+1:HGT_W-1] == 3'b111) begin
      hgt_nxt = sum[HGT_W-1:0];
    end else if (sum[HGT_W+1]) begin
      hgt_nxt = {1'b1, {(HGT_W-1){1'b0}}};
    end else begin
      hgt_nxt = {1'b0, {(HGT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy5) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_x_r   <= side4_r.x;
      out_y_r   <= side4_r.y;
      out_hgt_r <= hgt_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_height = out_hgt_r;

endmodule

@@ design/rhb_chk.sv @@
// ----------------------------------------------------------------------------
// rhb_chk
// Port-level checks on the brush core, bound to the top level.
// ----------------------------------------------------------------------------
module rhb_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [rhb_pkg::CRD_W-1:0]        out_x,
  input logic [rhb_pkg::CRD_W-1:0]        out_y,
  input logic signed [rhb_pkg::HGT_W-1:0] out_height
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_height))
    else $error("held output word changed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held while output side can move");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word after reset");

  a_no_early_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n, 1) && $past(rst_n, 2))
    else $error("output word too soon after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("input word dropped while stalled");

endmodule

bind radial_heightmap_brush_core rhb_chk u_rhb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_height (out_height)
);
